>>> rtl/positional_list_store_assert.svh
// ----------------------------------------------------------------------------
// Positional list store assertion macros
// Shorthand for the concurrent checks used inside the list store datapath.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_list_store: check failed");

// Next-cycle implication, disabled during reset.
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional_list_store: check failed");

`endif

>>> rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Command codes, controller states and the control and status bundles.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int FUNC_W = 3;
   localparam int POS_W  = 8;
   localparam int VAL_W  = 8;
   localparam int CNT_W  = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_GET    = 3'd1,
      FUNC_LOCATE = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_DELETE = 3'd4
   } pls_func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_INS_WR,
      ST_DONE
   } pls_state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic walk;
      logic ins_write;
      logic respond;
   } pls_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              legal;
      logic              moves;
      logic              walk_last;
      logic              out_free;
   } pls_stat_type;

endpackage

>>> rtl/pls_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list store controller
// Sequences each command through check and response, with entry walk and insert write as needed.
// ----------------------------------------------------------------------------
module pls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pls_pkg::pls_stat_type stat,
   output pls_pkg::pls_cmd_type  cmd
);

   import pls_pkg::*;

   pls_state_type state_ff;
   pls_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.legal) begin
               state_in = ST_DONE;
            end else begin
               case (stat.func)
                  FUNC_GET, FUNC_LOCATE, FUNC_DELETE: state_in = ST_WALK;
                  FUNC_INSERT: state_in = stat.moves ? ST_WALK : ST_INS_WR;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (stat.walk_last) begin
               state_in = (stat.func == FUNC_INSERT) ? ST_INS_WR : ST_DONE;
            end
         end
         ST_INS_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK:  cmd.check     = 1'b1;
         ST_WALK:   cmd.walk      = 1'b1;
         ST_INS_WR: cmd.ins_write = 1'b1;
         ST_DONE:   cmd.respond   = stat.out_free;
         default:   cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/pls_dp.sv
// ----------------------------------------------------------------------------
// Positional list store datapath
// Entry memory, length, walk address, result capture and output register.
// ----------------------------------------------------------------------------
`include "positional_list_store_assert.svh"

module pls_dp #(
   parameter int CAPACITY = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pls_pkg::pls_cmd_type         cmd,
   output pls_pkg::pls_stat_type        stat,
   input  logic [pls_pkg::FUNC_W-1:0]   req_func,
   input  logic [pls_pkg::POS_W-1:0]    req_position,
   input  logic [pls_pkg::VAL_W-1:0]    req_item_value,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [pls_pkg::VAL_W-1:0]    rsp_read_value,
   output logic [pls_pkg::CNT_W-1:0]    rsp_found_position,
   output logic [pls_pkg::CNT_W-1:0]    rsp_count
);

   import pls_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int WW = ((LW > POS_W) ? LW : POS_W) + 1;

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     prev_ff, prev_in;
   logic              res_ok_ff, res_ok_in;
   logic [VAL_W-1:0]  res_rd_ff, res_rd_in;
   logic [CNT_W-1:0]  res_found_ff, res_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [VAL_W-1:0]  rsp_rd_ff, rsp_rd_in;
   logic [CNT_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [WW-1:0]     pos_w, len_w, prev_w, one_w, req_pos_w, start_w, found_w;
   logic              legal, first, match, walk_last;
   logic              del_done;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [VAL_W-1:0]  rd_data;

   assign pos_w     = WW'(pos_ff);
   assign len_w     = WW'(len_ff);
   assign prev_w    = WW'(prev_ff);
   assign one_w     = WW'(1);
   assign req_pos_w = WW'(req_position);
   assign found_w   = prev_w + one_w;
   assign first     = (prev_w == pos_w - one_w);
   assign match     = (rd_data == val_ff);

   always_comb begin
      case (func_ff)
         FUNC_CLEAR:  legal = 1'b1;
         FUNC_GET:    legal = (pos_w != '0) && (pos_w <= len_w);
         FUNC_LOCATE: legal = (len_w != '0);
         FUNC_INSERT: legal = (pos_w != '0) && (pos_w <= len_w + one_w) &&
                              (len_w < WW'(CAPACITY));
         FUNC_DELETE: legal = (pos_w != '0) && (pos_w <= len_w);
         default:     legal = 1'b0;
      endcase
   end

   always_comb begin
      case (func_ff)
         FUNC_LOCATE: walk_last = match || (prev_w == len_w - one_w);
         FUNC_INSERT: walk_last = first;
         FUNC_DELETE: walk_last = (prev_w == len_w - one_w);
         default:     walk_last = 1'b1;
      endcase
   end

   assign del_done = cmd.walk && walk_last && (func_ff == FUNC_DELETE);

   always_comb begin
      case (req_func)
         FUNC_INSERT:           start_w = WW'(len_ff) - one_w;
         FUNC_GET, FUNC_DELETE: start_w = req_pos_w - one_w;
         default:               start_w = '0;
      endcase
   end

   always_comb begin
      stat.func      = func_ff;
      stat.legal     = legal;
      stat.moves     = (pos_w <= len_w);
      stat.walk_last = walk_last;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(prev_w + one_w);
      wr_data = rd_data;
      if (cmd.walk && (func_ff == FUNC_INSERT)) begin
         wr_en = 1'b1;
      end
      if (cmd.walk && (func_ff == FUNC_DELETE) && !first) begin
         wr_en   = 1'b1;
         wr_addr = AW'(prev_w - one_w);
      end
      if (cmd.ins_write) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pos_w - one_w);
         wr_data = val_ff;
      end
   end

   pls_ram #(
      .WIDTH(VAL_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      func_in      = func_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      prev_in      = prev_ff;
      res_ok_in    = res_ok_ff;
      res_rd_in    = res_rd_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;

      if (cmd.load) begin
         func_in      = req_func;
         pos_in       = req_position;
         val_in       = req_item_value;
         addr_in      = AW'(start_w);
         res_ok_in    = 1'b0;
         res_rd_in    = '0;
         res_found_in = '0;
      end

      if (cmd.check || cmd.walk) begin
         prev_in = addr_ff;
         addr_in = (func_ff == FUNC_INSERT) ? addr_ff - AW'(1) : addr_ff + AW'(1);
      end

      if (cmd.check && (func_ff == FUNC_CLEAR)) begin
         len_in    = '0;
         res_ok_in = 1'b1;
      end

      if (cmd.walk) begin
         case (func_ff)
            FUNC_GET: begin
               res_ok_in = 1'b1;
               res_rd_in = rd_data;
            end
            FUNC_LOCATE: begin
               if (match) begin
                  res_ok_in    = 1'b1;
                  res_found_in = found_w[CNT_W-1:0];
               end
            end
            FUNC_DELETE: begin
               if (first) begin
                  res_rd_in = rd_data;
               end
               if (walk_last) begin
                  res_ok_in = 1'b1;
                  len_in    = len_ff - LW'(1);
               end
            end
            default: res_ok_in = res_ok_ff;
         endcase
      end

      if (cmd.ins_write) begin
         len_in    = len_ff + LW'(1);
         res_ok_in = 1'b1;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_rd_in    = res_rd_ff;
         rsp_found_in = res_found_ff;
         rsp_count_in = len_w[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      addr_ff      <= addr_in;
      prev_ff      <= prev_in;
      res_ok_ff    <= res_ok_in;
      res_rd_ff    <= res_rd_in;
      res_found_ff <= res_found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;

   `PLS_ASSERT_IMP(a_len_cap, clock, reset, 1'b1, len_ff <= LW'(CAPACITY))
   `PLS_ASSERT_IMP(a_ins_room, clock, reset, cmd.ins_write, len_ff < LW'(CAPACITY))
   `PLS_ASSERT_IMP(a_rsp_free, clock, reset, cmd.respond, !rsp_valid_ff || !rsp_stall)
   `PLS_ASSERT_NEXT(a_load_clr, clock, reset, cmd.load, !res_ok_ff)
   `PLS_ASSERT_NEXT(a_del_len, clock, reset, del_done, len_ff == $past(len_ff) - LW'(1))

endmodule

>>> rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// Positional list store
// Bounded ordered list of bytes with clear, get, locate, insert and delete.
// ----------------------------------------------------------------------------
// One command is in work at a time: a new one is taken only once the last has
// been passed to the output register. The walk over the entry RAM moves one
// entry per cycle through its ports. A finished item waits in the output
// register while the next is accepted. Reset empties the list; stored entries
// are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int CAPACITY = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pls_pkg::FUNC_W-1:0] req_func,
   input  logic [pls_pkg::POS_W-1:0]  req_position,
   input  logic [pls_pkg::VAL_W-1:0]  req_item_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ok,
   output logic [pls_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [pls_pkg::CNT_W-1:0]  rsp_found_position,
   output logic [pls_pkg::CNT_W-1:0]  rsp_count
);

   import pls_pkg::*;

   pls_cmd_type  cmd;
   pls_stat_type stat;

   pls_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   pls_dp #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_read_value    (rsp_read_value),
      .rsp_found_position(rsp_found_position),
      .rsp_count         (rsp_count)
   );

endmodule

>>> tb/positional_list_store_tb.sv
// ----------------------------------------------------------------------------
// Positional list store testbench
// Drives list commands through the valid/stall request channel and checks each
// response against a predictor that keeps its own copy of the list. A short
// directed sequence covers bounds, duplicates and reserved commands. Random
// phases then grow the list to capacity, shrink it and mix commands. These
// phases run with no idling, with sender gaps, with receiver stalls, with both,
// and with one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module positional_list_store_tb;
   import pls_pkg::*;

   localparam int CAPACITY = 128;
   localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} list_mix_type;

   typedef struct packed {
      logic             ok;
      logic [VAL_W-1:0] read_value;
      logic [CNT_W-1:0] found_position;
      logic [CNT_W-1:0] count;
   } list_result_type;

   class list_scoreboard;
      logic [VAL_W-1:0] entries [CAPACITY];
      int unsigned      length;
      list_result_type  expected_q [$];
      int               errors;

      function new();
         foreach (entries[k]) entries[k] = '0;
         length = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_command(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
         list_result_type res;
         int unsigned     p;
         p = pos;
         res = '0;
         case (pls_func_type'(func))
            FUNC_CLEAR: begin
               length = 0;
               res.ok = 1'b1;
            end
            FUNC_GET: begin
               if (p >= 1 && p <= length) begin
                  res.read_value = entries[p-1];
                  res.ok = 1'b1;
               end
            end
            FUNC_LOCATE: begin
               for (int k = 0; k < length; k++) begin
                  if (entries[k] == val) begin
                     res.found_position = CNT_W'(k + 1);
                     res.ok = 1'b1;
                     break;
                  end
               end
            end
            FUNC_INSERT: begin
               if (p >= 1 && p <= length + 1 && length < CAPACITY) begin
                  for (int k = length; k > p - 1; k--) entries[k] = entries[k-1];
                  entries[p-1] = val;
                  length++;
                  res.ok = 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (p >= 1 && p <= length) begin
                  res.read_value = entries[p-1];
                  for (int k = p - 1; k < length - 1; k++) entries[k] = entries[k+1];
                  length--;
                  res.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         res.count = CNT_W'(length);
         expected_q.push_back(res);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         errors++;
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      endtask

      task check_result(list_result_type got);
         list_result_type want;
         if (expected_q.size() == 0) begin
            report("unexpected item, ok", got.ok, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.ok !== want.ok) report("ok", got.ok, want.ok);
            if (got.read_value !== want.read_value)
               report("read_value", got.read_value, want.read_value);
            if (got.found_position !== want.found_position)
               report("found_position", got.found_position, want.found_position);
            if (got.count !== want.count) report("count", got.count, want.count);
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [FUNC_W-1:0] req_func;
   logic [POS_W-1:0]  req_position;
   logic [VAL_W-1:0]  req_item_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_ok;
   logic [VAL_W-1:0]  rsp_read_value;
   logic [CNT_W-1:0]  rsp_found_position;
   logic [CNT_W-1:0]  rsp_count;

   int unsigned    sender_idle_pct;
   int unsigned    receiver_stall_pct;
   logic           pressure_start;
   logic           hold_active;
   list_scoreboard sb;

   positional_list_store #(.CAPACITY(CAPACITY)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= hold_active || ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_ok, rsp_read_value, rsp_found_position, rsp_count});
      end
   end

   initial begin
      hold_active = 1'b0;
      wait (pressure_start);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   initial begin
      #1_500_000;
      $display("positional_list_store verification failed");
      $finish;
   end

   task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_position   <= pos;
      req_item_value <= val;
      do @(posedge clock); while (req_stall);
      sb.note_command(func, pos, val);
      @(negedge clock);
   endtask

   task automatic random_command(input list_mix_type mix);
      int unsigned       roll, len, hi, ins_w, del_w, clr_w;
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  val;
      len = sb.length;
      case (mix)
         MIX_GROW: begin
            ins_w = 82; del_w = 4; clr_w = 0;
         end
         MIX_SHRINK: begin
            ins_w = 8; del_w = 78; clr_w = 0;
         end
         default: begin
            ins_w = 35; del_w = 30; clr_w = 3;
         end
      endcase
      roll = $urandom_range(99);
      if (roll == 0) func = FUNC_W'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
      else if (roll <= clr_w) func = FUNC_CLEAR;
      else if (roll <= clr_w + ins_w) func = FUNC_INSERT;
      else if (roll <= clr_w + ins_w + del_w) func = FUNC_DELETE;
      else if (roll[0]) func = FUNC_GET;
      else func = FUNC_LOCATE;
      hi = (func == FUNC_INSERT) ? len + 1 : len;
      if (hi > CAPACITY) hi = CAPACITY;
      if (hi == 0 || $urandom_range(9) == 0) pos = POS_W'($urandom_range(0, CAPACITY));
      else pos = POS_W'($urandom_range(1, hi));
      if (func == FUNC_LOCATE && len > 0 && $urandom_range(2) != 0)
         val = sb.entries[$urandom_range(0, len - 1)];
      else if ($urandom_range(1) == 1) val = VAL_W'($urandom_range(0, 255));
      else val = VAL_W'($urandom_range(0, 7));
      send_cmd(func, pos, val);
   endtask

   task automatic random_phase(input list_mix_type mix, input int n, input int unsigned idle_pct,
                               input int unsigned stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (n) random_command(mix);
   endtask

   initial begin
      sb                 = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_func           = FUNC_CLEAR;
      req_position       = '0;
      req_item_value     = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      pressure_start     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_cmd(FUNC_GET,    8'd1,   8'd0);
      send_cmd(FUNC_DELETE, 8'd1,   8'd0);
      send_cmd(FUNC_LOCATE, 8'd0,   8'd0);
      send_cmd(FUNC_INSERT, 8'd0,   8'd5);
      send_cmd(FUNC_INSERT, 8'd2,   8'd5);
      send_cmd(FUNC_INSERT, 8'd1,   8'd0);
      send_cmd(FUNC_INSERT, 8'd2,   8'd255);
      send_cmd(FUNC_INSERT, 8'd1,   8'd128);
      send_cmd(FUNC_INSERT, 8'd2,   8'd127);
      send_cmd(FUNC_INSERT, 8'd5,   8'd0);
      send_cmd(FUNC_LOCATE, 8'd0,   8'd0);
      send_cmd(FUNC_LOCATE, 8'd128, 8'd255);
      send_cmd(FUNC_LOCATE, 8'd1,   8'd85);
      send_cmd(FUNC_GET,    8'd0,   8'd0);
      send_cmd(FUNC_GET,    8'd6,   8'd0);
      send_cmd(FUNC_GET,    8'd5,   8'd0);
      send_cmd(FUNC_GET,    8'd128, 8'd0);
      send_cmd(FUNC_DELETE, 8'd6,   8'd0);
      send_cmd(FUNC_DELETE, 8'd2,   8'd0);
      send_cmd(FUNC_DELETE, 8'd4,   8'd0);
      send_cmd(FUNC_DELETE, 8'd0,   8'd0);
      send_cmd(FUNC_RSVD5,  8'd1,   8'd0);
      send_cmd(FUNC_RSVD6,  8'd128, 8'd255);
      send_cmd(FUNC_RSVD7,  8'd3,   8'd0);
      send_cmd(FUNC_CLEAR,  8'd0,   8'd0);
      send_cmd(FUNC_GET,    8'd1,   8'd0);

      random_phase(MIX_GROW, 220, 0, 0);
      pressure_start = 1'b1;
      random_phase(MIX_BALANCED, 20, 0, 0);
      random_phase(MIX_SHRINK, 140, 87, 0);
      random_phase(MIX_BALANCED, 80, 0, 87);
      random_phase(MIX_BALANCED, 80, 12, 12);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("positional_list_store verification clean");
      end else begin
         $display("positional_list_store verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/pls_dp.sv
rtl/positional_list_store.sv
tb/positional_list_store_tb.sv
